// File: rtl/core/eaq_pkg.sv
`default_nettype none
package eaq_pkg;

    localparam int ANGLE_BITS     = 17;
    localparam int QUAT_FRAC_BITS = 14;
    localparam int OUT_BITS       = QUAT_FRAC_BITS + 2;
    localparam int CORDIC_STEPS   = 30;
    localparam int CW             = 32;   // cordic datapath width
    localparam int LANE_LAT       = CORDIC_STEPS + 2;
    localparam int MERGE_LAT      = 3;
    localparam int TOTAL_LAT      = LANE_LAT + MERGE_LAT;

    localparam logic signed [CW-1:0] CORDIC_GAIN_INV = 32'sd652032874;
    localparam logic signed [CW-1:0] EIGHTH_TURN     = 32'sd536870912;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef logic signed [CW-1:0] cw_t;
    typedef logic signed [OUT_BITS-1:0] quat_t;

    // arctan(2^-i) in 2^32 counts per turn
    localparam cw_t ATAN_TURN32 [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

endpackage
`default_nettype wire

// File: rtl/core/eaq_cordic_lane.sv
`default_nettype none
module eaq_cordic_lane
    import eaq_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  advance,
    input  wire logic [ANGLE_BITS-1:0] angle,
    output cw_t                        cos_half,
    output cw_t                        sin_half
);

    // raw angle bits are the half-angle phase modulo one turn
    logic [CW-1:0] phase;
    logic [CW-1:0] shifted;
    cw_t           z_start;

    cw_t        x_reg [CORDIC_STEPS+1];
    cw_t        y_reg [CORDIC_STEPS+1];
    // z only steers, so the last stage has none
    cw_t        z_reg [CORDIC_STEPS];
    logic [1:0] quad_reg [CORDIC_STEPS+1];
    cw_t        cos_reg;
    cw_t        sin_reg;
    cw_t        cos_next;
    cw_t        sin_next;

    assign phase   = {angle, {(CW-ANGLE_BITS){1'b0}}};
    assign shifted = phase + EIGHTH_TURN;
    assign z_start = $signed({2'b00, shifted[CW-3:0]}) - EIGHTH_TURN;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg[0]    <= CORDIC_GAIN_INV;
            y_reg[0]    <= '0;
            z_reg[0]    <= z_start;
            quad_reg[0] <= shifted[CW-1:CW-2];
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        cw_t dx;
        cw_t dy;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                quad_reg[i+1] <= quad_reg[i];
                if (!z_reg[i][CW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                end
            end
        end

        if (i < CORDIC_STEPS - 1)
        begin : g_z
            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    if (!z_reg[i][CW-1])
                        z_reg[i+1] <= z_reg[i] - ATAN_TURN32[i];
                    else
                        z_reg[i+1] <= z_reg[i] + ATAN_TURN32[i];
                end
            end
        end
    end

    // quadrant rotation of (c, s)
    always_comb
    begin
        case (quad_reg[CORDIC_STEPS])
            QUAD_0:
            begin
                cos_next = x_reg[CORDIC_STEPS];
                sin_next = y_reg[CORDIC_STEPS];
            end
            QUAD_1:
            begin
                cos_next = -y_reg[CORDIC_STEPS];
                sin_next = x_reg[CORDIC_STEPS];
            end
            QUAD_2:
            begin
                cos_next = -x_reg[CORDIC_STEPS];
                sin_next = -y_reg[CORDIC_STEPS];
            end
            default:
            begin
                cos_next = y_reg[CORDIC_STEPS];
                sin_next = -x_reg[CORDIC_STEPS];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign cos_half = cos_reg;
    assign sin_half = sin_reg;

endmodule
`default_nettype wire

// File: rtl/core/eaq_merge.sv
`default_nettype none
module eaq_merge
    import eaq_pkg::*;
(
    input  wire logic clk,
    input  wire logic advance,
    input  cw_t       ch,
    input  cw_t       sh,
    input  cw_t       cr,
    input  cw_t       sr,
    input  cw_t       cp,
    input  cw_t       sp,
    output quat_t     quat_w,
    output quat_t     quat_x,
    output quat_t     quat_y,
    output quat_t     quat_z
);

    localparam int PW  = 2 * CW;        // pair product
    localparam int AW  = PW - 30;       // pair at 2^30 scale
    localparam int TW  = AW + CW;       // triple at 2^60 scale
    localparam int SW  = TW + 1;
    localparam int SH  = 60 - QUAT_FRAC_BITS;
    localparam int QW  = SW - SH;

    typedef logic signed [AW-1:0] pair_t;
    typedef logic signed [TW-1:0] trip_t;
    typedef logic signed [SW-1:0] sum_t;

    // stage 1: the four pair products, rounded half up to 2^30
    logic signed [PW-1:0] p_chcp, p_shsp, p_chsp, p_shcp;
    pair_t chcp_reg, shsp_reg, chsp_reg, shcp_reg;
    cw_t   cr_reg, sr_reg;

    assign p_chcp = PW'(ch) * PW'(cp) + (PW'(1) <<< 29);
    assign p_shsp = PW'(sh) * PW'(sp) + (PW'(1) <<< 29);
    assign p_chsp = PW'(ch) * PW'(sp) + (PW'(1) <<< 29);
    assign p_shcp = PW'(sh) * PW'(cp) + (PW'(1) <<< 29);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            chcp_reg <= p_chcp[PW-1:30];
            shsp_reg <= p_shsp[PW-1:30];
            chsp_reg <= p_chsp[PW-1:30];
            shcp_reg <= p_shcp[PW-1:30];
            cr_reg   <= cr;
            sr_reg   <= sr;
        end
    end

    // stage 2: third factor at full precision
    trip_t t_w0_reg, t_w1_reg, t_x0_reg, t_x1_reg;
    trip_t t_y0_reg, t_y1_reg, t_z0_reg, t_z1_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            t_w0_reg <= TW'(chcp_reg) * TW'(cr_reg);
            t_w1_reg <= TW'(shsp_reg) * TW'(sr_reg);
            t_x0_reg <= TW'(chcp_reg) * TW'(sr_reg);
            t_x1_reg <= TW'(shsp_reg) * TW'(cr_reg);
            t_y0_reg <= TW'(shcp_reg) * TW'(cr_reg);
            t_y1_reg <= TW'(chsp_reg) * TW'(sr_reg);
            t_z0_reg <= TW'(chsp_reg) * TW'(cr_reg);
            t_z1_reg <= TW'(shcp_reg) * TW'(sr_reg);
        end
    end

    // stage 3: combine, round, clamp to +-1.0
    function automatic quat_t to_quat(input sum_t v);
        sum_t                 r;
        logic signed [QW-1:0] q;
        r = v + (SW'(1) <<< (SH - 1));
        q = r[SW-1:SH];
        if (q > QW'(1 << QUAT_FRAC_BITS))
            return OUT_BITS'(1 << QUAT_FRAC_BITS);
        else if (q < -QW'(1 << QUAT_FRAC_BITS))
            return -OUT_BITS'(1 << QUAT_FRAC_BITS);
        else
            return q[OUT_BITS-1:0];
    endfunction

    quat_t w_reg, x_reg, y_reg, z_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            w_reg <= to_quat(SW'(t_w0_reg) - SW'(t_w1_reg));
            x_reg <= to_quat(SW'(t_x0_reg) + SW'(t_x1_reg));
            y_reg <= to_quat(SW'(t_y0_reg) + SW'(t_y1_reg));
            z_reg <= to_quat(SW'(t_z0_reg) - SW'(t_z1_reg));
        end
    end

    assign quat_w = w_reg;
    assign quat_x = x_reg;
    assign quat_y = y_reg;
    assign quat_z = z_reg;

endmodule
`default_nettype wire

// File: rtl/core/euler_angles_to_quaternion.sv
`default_nettype none
// Euler angles (heading, roll, pitch) to rotation quaternion, Q1.14 out.
//
// Input channel: angle_valid / angle_stall with heading_angle, roll_angle,
//   pitch_angle; an item is taken on an edge with valid high, stall low.
// Output channel: quat_valid / quat_stall with quat_w/x/y/z, saturated
//   to +-1.0 (16384).
// Pipeline from accept to quat_valid: 1 phase prep, 30 CORDIC stages,
//   1 quadrant fix, 3 product/round stages.
// Throughput: one item per cycle unless a held result stalls it; three CORDIC
//   lanes run side by side, one per angle; the merge forms the triple products.
// Stall: the whole pipeline holds in place while a result waits at the
//   output with quat_stall high; angle_stall follows in the same cycle,
//   so input is held off for as long as the result waits.
// Reset: rst_n clears all stage valid bits; no item is in flight after.
// The block holds no state between items.
module euler_angles_to_quaternion
    import eaq_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         angle_valid,
    output logic                              angle_stall,
    input  wire logic signed [ANGLE_BITS-1:0] heading_angle,
    input  wire logic signed [ANGLE_BITS-1:0] roll_angle,
    input  wire logic signed [ANGLE_BITS-1:0] pitch_angle,
    output logic                              quat_valid,
    input  wire logic                         quat_stall,
    output quat_t                             quat_w,
    output quat_t                             quat_x,
    output quat_t                             quat_y,
    output quat_t                             quat_z
);

    logic                 advance;
    logic [TOTAL_LAT-1:0] valid_reg;
    logic [TOTAL_LAT-1:0] valid_next;

    // pipeline moves unless a finished item is held by the receiver
    assign advance     = !(valid_reg[TOTAL_LAT-1] && quat_stall);
    assign angle_stall = !advance;
    assign quat_valid  = valid_reg[TOTAL_LAT-1];

    assign valid_next = advance ? {valid_reg[TOTAL_LAT-2:0], angle_valid} : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    cw_t ch, sh, cr, sr, cp, sp;

    eaq_cordic_lane u_lane_heading (
        .clk      (clk),
        .advance  (advance),
        .angle    (heading_angle),
        .cos_half (ch),
        .sin_half (sh)
    );

    eaq_cordic_lane u_lane_roll (
        .clk      (clk),
        .advance  (advance),
        .angle    (roll_angle),
        .cos_half (cr),
        .sin_half (sr)
    );

    eaq_cordic_lane u_lane_pitch (
        .clk      (clk),
        .advance  (advance),
        .angle    (pitch_angle),
        .cos_half (cp),
        .sin_half (sp)
    );

    eaq_merge u_merge (
        .clk     (clk),
        .advance (advance),
        .ch      (ch),
        .sh      (sh),
        .cr      (cr),
        .sr      (sr),
        .cp      (cp),
        .sp      (sp),
        .quat_w  (quat_w),
        .quat_x  (quat_x),
        .quat_y  (quat_y),
        .quat_z  (quat_z)
    );

endmodule
`default_nettype wire

// File: rtl/core/eaq_checker.sv
`default_nettype none
module eaq_checker
    import eaq_pkg::*;
(
    input wire logic  clk,
    input wire logic  rst_n,
    input wire logic  angle_stall,
    input wire logic  quat_valid,
    input wire logic  quat_stall,
    input wire quat_t quat_w,
    input wire quat_t quat_x,
    input wire quat_t quat_y,
    input wire quat_t quat_z
);

    // held result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        quat_valid && quat_stall |=> quat_valid)
        else $error("quat_valid dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        quat_valid && quat_stall |=> $stable(quat_w) && $stable(quat_x)
                                     && $stable(quat_y) && $stable(quat_z))
        else $error("quat payload moved while stalled");

    // input backpressure comes only from a held result
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        angle_stall == (quat_valid && quat_stall))
        else $error("angle_stall without a held result");

    // components stay inside +-1.0
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        quat_valid |-> (quat_w <= 16'sd16384) && (quat_w >= -16'sd16384)
                    && (quat_x <= 16'sd16384) && (quat_x >= -16'sd16384)
                    && (quat_y <= 16'sd16384) && (quat_y >= -16'sd16384)
                    && (quat_z <= 16'sd16384) && (quat_z >= -16'sd16384))
        else $error("quaternion component out of range");

endmodule

bind euler_angles_to_quaternion eaq_checker u_eaq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .angle_stall (angle_stall),
    .quat_valid  (quat_valid),
    .quat_stall  (quat_stall),
    .quat_w      (quat_w),
    .quat_x      (quat_x),
    .quat_y      (quat_y),
    .quat_z      (quat_z)
);
`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 100ps
`default_nettype none

// Quaternion scoreboard: holds expected (w, x, y, z) per accepted angle triple.
class quat_scoreboard;
    eaq_pkg::quat_t pending_w[$];
    eaq_pkg::quat_t pending_x[$];
    eaq_pkg::quat_t pending_y[$];
    eaq_pkg::quat_t pending_z[$];
    int mismatches;

    function void note_angles(eaq_pkg::quat_t w, eaq_pkg::quat_t x,
                              eaq_pkg::quat_t y, eaq_pkg::quat_t z);
        pending_w.push_back(w);
        pending_x.push_back(x);
        pending_y.push_back(y);
        pending_z.push_back(z);
    endfunction

    function void check_quat(eaq_pkg::quat_t w, eaq_pkg::quat_t x,
                             eaq_pkg::quat_t y, eaq_pkg::quat_t z);
        eaq_pkg::quat_t ew, ex, ey, ez;
        if (pending_w.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected quaternion %0d %0d %0d %0d", w, x, y, z);
            return;
        end
        ew = pending_w.pop_front();
        ex = pending_x.pop_front();
        ey = pending_y.pop_front();
        ez = pending_z.pop_front();
        if (w !== ew || x !== ex || y !== ey || z !== ez)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("quat mismatch: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                         ew, ex, ey, ez, w, x, y, z);
        end
    endfunction

    function int outstanding();
        return pending_w.size();
    endfunction
endclass

module testbench;
    import eaq_pkg::*;

    localparam int N_RANDOM    = 900;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 80;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic angle_valid = 1'b0;
    logic angle_stall;
    logic signed [ANGLE_BITS-1:0] heading_angle = '0;
    logic signed [ANGLE_BITS-1:0] roll_angle = '0;
    logic signed [ANGLE_BITS-1:0] pitch_angle = '0;
    logic quat_valid;
    logic quat_stall = 1'b0;
    quat_t quat_w, quat_x, quat_y, quat_z;

    quat_scoreboard sb = new();
    int  cycle_count = 0;
    bit  idle_free = 1'b0;     // last part of the run: no bubbles, no stalls
    bit  hold_go = 1'b0;       // starts the long receiver hold-off
    int  hold_count = 0;       // cycles of hold-off so far
    int  stall_left = 0;       // remaining cycles of a short stall burst

    always #2 clk = ~clk;

    euler_angles_to_quaternion u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .angle_valid  (angle_valid),
        .angle_stall  (angle_stall),
        .heading_angle(heading_angle),
        .roll_angle   (roll_angle),
        .pitch_angle  (pitch_angle),
        .quat_valid   (quat_valid),
        .quat_stall   (quat_stall),
        .quat_w       (quat_w),
        .quat_x       (quat_x),
        .quat_y       (quat_y),
        .quat_z       (quat_z)
    );

    // ---------------- predictor ----------------
    // floor(v / 2^k), arithmetic shift does exactly this on signed longint
    function automatic longint floor_shift(longint v, int k);
        return v >>> k;
    endfunction

    // cos/sin of a half angle; the raw angle bits are the phase of a
    // 2^ANGLE_BITS turn, scaled to 32 bits per turn. 2^30 = 1.0.
    function automatic void half_cos_sin(logic [ANGLE_BITS-1:0] raw,
                                         output longint c, output longint s);
        logic [31:0] phase, shifted;
        logic [1:0] quadrant;
        longint x, y, z, dx, dy;
        phase = {raw, {(32 - ANGLE_BITS){1'b0}}};
        shifted = phase + 32'h2000_0000;   // round to nearest quarter turn
        quadrant = shifted[31:30];
        z = longint'({2'b00, shifted[29:0]}) - 64'sh2000_0000;
        x = CORDIC_GAIN_INV;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= longint'(ATAN_TURN32[i]);
            end
            else
            begin
                x += dx;
                y -= dy;
                z += longint'(ATAN_TURN32[i]);
            end
        end
        case (quadrant)
            QUAD_0: begin c = x;  s = y;  end
            QUAD_1: begin c = -y; s = x;  end
            QUAD_2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    // pair product rounded half up to 2^30, third factor at full precision
    function automatic longint triple_prod(longint a, longint b, longint c);
        return floor_shift(a * b + (64'sd1 <<< 29), 30) * c;
    endfunction

    function automatic quat_t to_q14(longint v60);
        longint q, one;
        one = 64'sd1 <<< QUAT_FRAC_BITS;
        q = floor_shift(v60 + (64'sd1 <<< (59 - QUAT_FRAC_BITS)), 60 - QUAT_FRAC_BITS);
        if (q > one)
            q = one;
        if (q < -one)
            q = -one;
        return quat_t'(q);
    endfunction

    function automatic void predict_quat(logic [ANGLE_BITS-1:0] hd,
                                         logic [ANGLE_BITS-1:0] rl,
                                         logic [ANGLE_BITS-1:0] pt);
        longint ch, sh, cr, sr, cp, sp;
        half_cos_sin(hd, ch, sh);
        half_cos_sin(rl, cr, sr);
        half_cos_sin(pt, cp, sp);
        sb.note_angles(to_q14(triple_prod(ch, cp, cr) - triple_prod(sh, sp, sr)),
                       to_q14(triple_prod(ch, cp, sr) + triple_prod(sh, sp, cr)),
                       to_q14(triple_prod(sh, cp, cr) + triple_prod(ch, sp, sr)),
                       to_q14(triple_prod(ch, sp, cr) - triple_prod(sh, cp, sr)));
    endfunction

    // ---------------- stimulus ----------------
    // offer one triple, holding it until the block takes it
    task automatic send_angles(logic [ANGLE_BITS-1:0] hd, logic [ANGLE_BITS-1:0] rl,
                               logic [ANGLE_BITS-1:0] pt, bit allow_gap);
        int gap;
        if (allow_gap && !idle_free && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 4);
            angle_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        angle_valid   <= 1'b1;
        heading_angle <= hd;
        roll_angle    <= rl;
        pitch_angle   <= pt;
        @(posedge clk);
        while (angle_stall)
            @(posedge clk);
        predict_quat(hd, rl, pt);
    endtask

    function automatic logic [ANGLE_BITS-1:0] rand_angle();
        case ($urandom_range(0, 7))
            0: return ANGLE_BITS'(32'h1_0000);   // -360 deg
            1: return ANGLE_BITS'(32'h0_FFFF);
            // near multiples of 90 deg (quadrant ties in the half angle)
            2: return ANGLE_BITS'($urandom_range(0, 7) * 32'h4000
                                  + $urandom_range(0, 4) - 2);
            default: return ANGLE_BITS'($urandom());
        endcase
    endfunction

    task automatic drain_wait();
        angle_valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    // long receiver hold-off, counted in its own process
    always @(posedge clk)
    begin
        if (hold_go && hold_count < LONG_HOLD)
            hold_count <= hold_count + 1;
    end

    // output side: random stall bursts, one long hold-off, check on accept
    always @(posedge clk)
    begin
        if (rst_n && quat_valid && !quat_stall)
            sb.check_quat(quat_w, quat_x, quat_y, quat_z);
        if (hold_go && hold_count < LONG_HOLD)
            quat_stall <= 1'b1;
        else if (idle_free)
            quat_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            quat_stall <= 1'b1;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            stall_left <= int'($urandom_range(0, 3));
            quat_stall <= 1'b1;
        end
        else
            quat_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench: FAIL");
            $finish;
        end
    end

    localparam logic [ANGLE_BITS-1:0] A_MIN  = ANGLE_BITS'(32'h1_0000);
    localparam logic [ANGLE_BITS-1:0] A_MAX  = ANGLE_BITS'(32'h0_FFFF);
    localparam logic [ANGLE_BITS-1:0] A_90   = ANGLE_BITS'(32'h0_4000);
    localparam logic [ANGLE_BITS-1:0] A_180  = ANGLE_BITS'(32'h0_8000);
    localparam logic [ANGLE_BITS-1:0] A_M1   = '1;

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero, extremes, right angles, quadrant boundaries
        send_angles('0, '0, '0, 1'b0);
        send_angles(A_MIN, A_MIN, A_MIN, 1'b0);
        send_angles(A_MAX, A_MAX, A_MAX, 1'b0);
        send_angles(A_M1, '0, A_MIN, 1'b0);
        send_angles(A_90, '0, '0, 1'b0);
        send_angles('0, A_90, '0, 1'b0);
        send_angles('0, '0, A_90, 1'b0);
        send_angles(A_180, A_180, A_180, 1'b0);
        send_angles(A_180, '0, '0, 1'b0);
        send_angles('0, A_180, A_90, 1'b0);
        send_angles(ANGLE_BITS'(32'h0_2000), ANGLE_BITS'(32'h1_E000), ANGLE_BITS'(1), 1'b0);
        send_angles(ANGLE_BITS'(32'h0_1FFF), ANGLE_BITS'(32'h0_6000), A_MAX, 1'b0);
        send_angles(ANGLE_BITS'(32'h1_5555), ANGLE_BITS'(32'h0_AAAA), A_M1, 1'b0);
        send_angles(A_90, A_90, A_90, 1'b0);

        // sender pause until everything is back
        drain_wait();

        // receiver holds off long while the sender keeps offering
        hold_go <= 1'b1;
        for (int i = 0; i < 60; i++)
            send_angles(rand_angle(), rand_angle(), rand_angle(), 1'b0);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM - 150)
                idle_free = 1'b1;
            send_angles(rand_angle(), rand_angle(), rand_angle(), 1'b1);
        end
        drain_wait();
        repeat (TOTAL_LAT + 10) @(posedge clk);

        if (sb.mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule

`default_nettype wire

// File: euler_angles_to_quaternion.f
rtl/core/eaq_pkg.sv
rtl/core/eaq_cordic_lane.sv
rtl/core/eaq_merge.sv
rtl/core/euler_angles_to_quaternion.sv
rtl/core/eaq_checker.sv
test/testbench.sv
